// ===== rtl/core/urrs_pkg.sv =====
package urrs_pkg;

  // Default random word width
  localparam int WORD_WIDTH_DEF = 32;

  // Configuration register index width
  localparam int CFG_IDX_W = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register map
  localparam cfg_idx_t REG_RANGE_LOW  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RANGE_HIGH = cfg_idx_t'(1);

endpackage

// ===== rtl/core/urrs_if.sv =====
// Random word channel
interface urrs_word_if #(
  parameter int WORD_WIDTH = urrs_pkg::WORD_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// Range value channel
interface urrs_value_if #(
  parameter int WORD_WIDTH = urrs_pkg::WORD_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/urrs_cfg_regs.sv =====
module urrs_cfg_regs
  import urrs_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [WORD_WIDTH-1:0] cfg_data,
  output logic [WORD_WIDTH-1:0] lo,
  output logic [WORD_WIDTH-1:0] span,
  output logic [WORD_WIDTH-1:0] span_m1,
  output logic                  full
);

  logic [WORD_WIDTH-1:0] range_low_r;
  logic [WORD_WIDTH-1:0] range_high_r;
  logic [WORD_WIDTH-1:0] lo_r, lo_nxt;
  logic [WORD_WIDTH-1:0] span_m1_r, span_m1_nxt;
  logic [WORD_WIDTH-1:0] hi_sw;

  // Capture register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Order the bounds and derive span minus one
  always_comb begin
    if ($signed(range_high_r) < $signed(range_low_r)) begin
      lo_nxt = range_high_r;
      hi_sw  = range_low_r;
    end else begin
      lo_nxt = range_low_r;
      hi_sw  = range_high_r;
    end
    span_m1_nxt = hi_sw - lo_nxt;
  end

  // Hold derived range values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r      <= '0;
      span_m1_r <= '0;
    end else begin
      lo_r      <= lo_nxt;
      span_m1_r <= span_m1_nxt;
    end
  end

  assign lo      = lo_r;
  assign span_m1 = span_m1_r;
  assign span    = span_m1_r + WORD_WIDTH'(1);
  assign full    = &span_m1_r;

endmodule

// ===== rtl/core/urrs_div_cell.sv =====
module urrs_div_cell
  import urrs_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [WORD_WIDTH-1:0] span,
  input  logic                  valid_in,
  input  logic [WORD_WIDTH-1:0] word_in,
  input  logic [WORD_WIDTH-1:0] rem_in,
  output logic                  valid_out,
  output logic [WORD_WIDTH-1:0] word_out,
  output logic [WORD_WIDTH-1:0] rem_out
);

  logic                  valid_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] rem_r, rem_nxt;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;

  // Shift in one dividend bit, subtract span when it fits
  always_comb begin
    trial = {rem_in, word_in[WORD_WIDTH-1-IDX]};
    diff  = trial - {1'b0, span};
    if (trial >= {1'b0, span}) begin
      rem_nxt = diff[WORD_WIDTH-1:0];
    end else begin
      rem_nxt = trial[WORD_WIDTH-1:0];
    end
  end

  // Advance the beat to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_in;
      rem_r  <= rem_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;
  assign rem_out   = rem_r;

endmodule

// ===== rtl/core/uniform_range_rejection_sampler_unit.sv =====
// Uniform range sampler with rejection.
// Input channel in_s carries one random word per beat; output channel out_m
// carries one signed value per kept word, uniform over the inclusive range
// set by registers range_low (index 0) and range_high (index 1). Bounds given
// in reverse are swapped. Words that would bias the result are dropped and
// produce no output beat.
// Write the range registers only while no beats are in flight; the derived
// span is registered from the range registers after a write.
// Throughput: one word per cycle while the output register is free. Each word
// accepted passes the chain of WORD_WIDTH divider cells (one dividend bit
// per cell) and then the output register before out_m.valid.
// Reset clears both range registers to zero and empties the chain; with equal
// bounds every word yields the bound.
// When the receiver stalls with a value waiting, the whole chain holds and
// in_s.ready drops; it returns as soon as the waiting value is taken.
module uniform_range_rejection_sampler_unit
  import urrs_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  urrs_word_if.sink             in_s,
  urrs_value_if.source          out_m,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [WORD_WIDTH-1:0] cfg_data
);

  logic [WORD_WIDTH-1:0] lo;
  logic [WORD_WIDTH-1:0] span;
  logic [WORD_WIDTH-1:0] span_m1;
  logic                  full;
  logic                  adv;

  logic                  cell_valid [WORD_WIDTH];
  logic [WORD_WIDTH-1:0] cell_word  [WORD_WIDTH];
  logic [WORD_WIDTH-1:0] cell_rem   [WORD_WIDTH];

  logic                  last_valid;
  logic [WORD_WIDTH-1:0] last_word;
  logic [WORD_WIDTH-1:0] last_rem;
  logic [WORD_WIDTH-1:0] base;
  logic [WORD_WIDTH:0]   top_sum;
  logic                  keep;

  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_WIDTH-1:0] value_r, value_nxt;

  urrs_cfg_regs #(.WORD_WIDTH(WORD_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lo        (lo),
    .span      (span),
    .span_m1   (span_m1),
    .full      (full)
  );

  // Chain advances whenever the output register is free
  assign adv        = !out_valid_r || out_m.ready;
  assign in_s.ready = adv;

  // Divider chain, most significant bit first
  for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      urrs_div_cell #(.WORD_WIDTH(WORD_WIDTH), .IDX(i)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .span      (span),
        .valid_in  (in_s.valid),
        .word_in   (in_s.random_word),
        .rem_in    ('0),
        .valid_out (cell_valid[i]),
        .word_out  (cell_word[i]),
        .rem_out   (cell_rem[i])
      );
    end else begin : g_next
      urrs_div_cell #(.WORD_WIDTH(WORD_WIDTH), .IDX(i)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .span      (span),
        .valid_in  (cell_valid[i-1]),
        .word_in   (cell_word[i-1]),
        .rem_in    (cell_rem[i-1]),
        .valid_out (cell_valid[i]),
        .word_out  (cell_word[i]),
        .rem_out   (cell_rem[i])
      );
    end
  end

  assign last_valid = cell_valid[WORD_WIDTH-1];
  assign last_word  = cell_word[WORD_WIDTH-1];
  assign last_rem   = cell_rem[WORD_WIDTH-1];

  // Keep the word only if its whole span-sized block fits below 2^WORD_WIDTH
  always_comb begin
    base    = last_word - last_rem;
    top_sum = {1'b0, base} + {1'b0, span_m1};
    keep    = full || !top_sum[WORD_WIDTH];
    out_valid_nxt = last_valid && keep;
    if (full) begin
      value_nxt = last_word;
    end else begin
      value_nxt = lo + last_rem;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
    end
  end

  assign out_m.valid = out_valid_r;
  assign out_m.value = value_r;

`ifndef SYNTHESIS
  // Outside the full range, the remainder leaving the chain is below the span
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (last_valid && !full) |-> (last_rem < span))
    else $error("remainder not below span");

  // Every delivered value lies inside the ordered range
  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !full) |->
      ((value_r - lo) <= span_m1))
    else $error("value outside range");

  // Equal bounds never drop a word
  a_equal_bounds_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_valid && (span_m1 == '0)) |=> out_valid_r)
    else $error("word dropped with equal bounds");

  // Full range passes the word through
  a_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_valid && full) |=> (out_valid_r && (value_r == $past(last_word))))
    else $error("full range word not passed through");
`endif

endmodule
